>>> src/dlcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift lifetime charge correction: shared types and constants
// Field widths, fixed-point formats, pipeline payload types and the
// constant function that builds the 2^(2^-k) factors.
// ----------------------------------------------------------------------------
package dlcc_pkg;

    localparam int CHARGE_W  = 24;
    localparam int TIME_W    = 24;
    localparam int LT_W      = 24;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = 22;
    localparam int M_W       = 31;
    localparam int L2E_W     = 31;
    localparam int N_W       = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = TIME_W + FRAC_W + 2;

    localparam logic [Q_W-1:0]   X_LIMIT   = Q_W'(32 << FRAC_W);
    localparam logic [L2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [M_W-1:0]   ONE_Q30   = M_W'(1 << 30);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EAST_EAST = 3'd0,
        REG_EAST_WEST = 3'd1,
        REG_WEST_EAST = 3'd2,
        REG_WEST_WEST = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        [CHARGE_W-1:0] charge_density;
        logic        [1:0]          cryostat;
        logic        [1:0]          tpc_number;
        logic signed [TIME_W-1:0]   hit_time;
        logic signed [TIME_W-1:0]   track_start;
    } in_t;

    typedef struct packed {
        logic [CHARGE_W-1:0] corrected_charge;
        logic                lifetime_applied;
        logic                saturated;
    } out_t;

    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic                apply;
        logic                neg;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic signed [N_W-1:0] exp_int;
    } exp_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 64'd0;
        x = v;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [M_W-1:0] exp2_root(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 0; j < k; j++) begin
            c = isqrt64(c << 30);
        end
        return M_W'(c);
    endfunction

endpackage

>>> src/dlcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Rounded drift-over-lifetime ratio, one quotient bit per stage, clamped.
// ----------------------------------------------------------------------------
module dlcc_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [dlcc_pkg::NUM_W-1:0] in_num,
    input  logic [dlcc_pkg::LT_W-1:0] in_tau,
    input  dlcc_pkg::side_t           in_side,
    output logic                      out_valid,
    output logic [dlcc_pkg::Q_W-1:0]  out_quo,
    output dlcc_pkg::side_t           out_side
);
    import dlcc_pkg::*;

    localparam int R0_W  = NUM_W - Q_W;
    localparam int CMP_W = (R0_W > LT_W) ? R0_W : LT_W;

    logic            valid_reg [0:Q_W];
    logic [LT_W-1:0] rem_reg   [0:Q_W];
    logic [Q_W-1:0]  low_reg   [0:Q_W];
    logic [Q_W-1:0]  quo_reg   [0:Q_W];
    logic            ovf_reg   [0:Q_W];
    logic [LT_W-1:0] tau_reg   [0:Q_W];
    side_t           side_reg  [0:Q_W];

    logic [R0_W-1:0] hi;
    logic            ovf_next;

    assign hi       = in_num[NUM_W-1:Q_W];
    assign ovf_next = CMP_W'(hi) >= CMP_W'(in_tau);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= LT_W'(hi);
            low_reg[0]  <= in_num[Q_W-1:0];
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= ovf_next;
            tau_reg[0]  <= in_tau;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [LT_W:0]   trial;
        logic            ge;
        logic [LT_W-1:0] rem_next;
        logic [Q_W-1:0]  quo_next;

        always_comb begin
            trial    = {rem_reg[k-1], low_reg[k-1][Q_W-k]};
            ge       = trial >= (LT_W+1)'(tau_reg[k-1]);
            rem_next = ge ? LT_W'(trial - (LT_W+1)'(tau_reg[k-1])) : trial[LT_W-1:0];
            quo_next = quo_reg[k-1];
            quo_next[Q_W-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_reg[k-1];
                quo_reg[k]  <= quo_next;
                ovf_reg[k]  <= ovf_reg[k-1];
                tau_reg[k]  <= tau_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_quo   = (ovf_reg[Q_W] || (quo_reg[Q_W] > X_LIMIT)) ? X_LIMIT : quo_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

>>> src/dlcc_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined fractional power of two
// 2^f in Q30, one conditional root-of-two multiply per fraction bit.
// ----------------------------------------------------------------------------
module dlcc_exp2 (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dlcc_pkg::FRAC_W-1:0] in_frac,
    input  dlcc_pkg::exp_side_t         in_side,
    output logic                        out_valid,
    output logic [dlcc_pkg::M_W-1:0]    out_mant,
    output dlcc_pkg::exp_side_t         out_side
);
    import dlcc_pkg::*;

    localparam logic [2*M_W-1:0] HALF = (2*M_W)'(1 << 29);

    logic              valid_reg [1:FRAC_W];
    logic [M_W-1:0]    mant_reg  [1:FRAC_W];
    logic [FRAC_W-1:0] frac_reg  [1:FRAC_W];
    exp_side_t         side_reg  [1:FRAC_W];

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_stage
        localparam logic [M_W-1:0] CK = exp2_root(k);

        logic              v_prev;
        logic [M_W-1:0]    m_prev;
        logic [FRAC_W-1:0] f_prev;
        exp_side_t         s_prev;
        logic [2*M_W-1:0]  prod;
        logic [M_W-1:0]    mant_next;

        if (k == 1) begin : g_first
            assign v_prev = in_valid;
            assign m_prev = ONE_Q30;
            assign f_prev = in_frac;
            assign s_prev = in_side;
        end else begin : g_rest
            assign v_prev = valid_reg[k-1];
            assign m_prev = mant_reg[k-1];
            assign f_prev = frac_reg[k-1];
            assign s_prev = side_reg[k-1];
        end

        always_comb begin
            prod      = (2*M_W)'(m_prev) * (2*M_W)'(CK);
            mant_next = f_prev[FRAC_W-k] ? M_W'((prod + HALF) >> 30) : m_prev;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mant_reg[k] <= mant_next;
                frac_reg[k] <= f_prev;
                side_reg[k] <= s_prev;
            end
        end
    end

    assign out_valid = valid_reg[FRAC_W];
    assign out_mant  = mant_reg[FRAC_W];
    assign out_side  = side_reg[FRAC_W];

endmodule

>>> src/drift_lifetime_charge_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift lifetime charge correction
// Scales each hit charge by exp(drift / lifetime) with a per-TPC-pair lifetime.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    in_t  (charge, cryostat, tpc, times)
//   m_       out        m_valid/m_ready    out_t (charge, applied, saturated)
//   cfg_     in         cfg_wr_en          cfg_addr, cfg_wr_data (lifetimes)
//
// One request per cycle while m_ready does not stall; stages: input stage, 23-stage
// divider, two log2(e) stages, 16-stage power-of-two unit, charge product, output.
// Synchronous active-low reset clears all stage valids and the lifetimes.
// A stall at m_ready freezes every stage together; nothing is lost.
// ----------------------------------------------------------------------------
module drift_lifetime_charge_correction (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dlcc_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dlcc_pkg::out_t                 m_data,
    input  logic                           cfg_wr_en,
    input  logic [dlcc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [dlcc_pkg::LT_W-1:0]      cfg_wr_data
);
    import dlcc_pkg::*;

    localparam int PROD_W = Q_W + L2E_W;
    localparam int P_W    = CHARGE_W + M_W;
    localparam int W_W    = P_W + 2;
    localparam logic [PROD_W-1:0]   Y_HALF  = PROD_W'(1 << 29);
    localparam logic [CHARGE_W-1:0] MAXV    = '1;
    localparam logic signed [N_W-1:0] N_SAT = N_W'(CHARGE_W);

    logic en;

    logic [LT_W-1:0] lifetime_reg [0:3];

    logic                a_valid_reg;
    side_t               a_side_reg;
    logic [TIME_W:0]     a_ad_reg;
    logic [LT_W-1:0]     a_tau_reg;

    logic                c_valid_reg;
    logic [PROD_W-1:0]   c_prod_reg;
    side_t               c_side_reg;

    logic                d_valid_reg;
    logic [FRAC_W-1:0]   d_frac_reg;
    exp_side_t           d_side_reg;

    logic                p_valid_reg;
    logic [P_W-1:0]      p_prod_reg;
    exp_side_t           p_side_reg;

    logic                m_valid_reg;
    out_t                m_data_reg;

    logic [LT_W-1:0]     tau_sel;
    logic [TIME_W:0]     diff;
    logic [TIME_W:0]     ad_next;
    side_t               a_side_next;
    logic [NUM_W-1:0]    num;

    logic                dv_valid;
    logic [Q_W-1:0]      dv_quo;
    side_t               dv_side;

    logic [Q_W-1:0]      ym;
    logic [FRAC_W-1:0]   d_frac_next;
    exp_side_t           d_side_next;

    logic                ex_valid;
    logic [M_W-1:0]      ex_mant;
    exp_side_t           ex_side;

    logic signed [N_W:0] shf;
    logic signed [N_W:0] shf_neg;
    logic [W_W-1:0]      wide;
    out_t                m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                lifetime_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EAST_EAST: lifetime_reg[0] <= cfg_wr_data;
                REG_EAST_WEST: lifetime_reg[1] <= cfg_wr_data;
                REG_WEST_EAST: lifetime_reg[2] <= cfg_wr_data;
                REG_WEST_WEST: lifetime_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_data.cryostat)
            2'd0:    tau_sel = lifetime_reg[{1'b0, s_data.tpc_number[1]}];
            2'd1:    tau_sel = lifetime_reg[{1'b1, s_data.tpc_number[1]}];
            default: tau_sel = '0;
        endcase
        diff    = {s_data.hit_time[TIME_W-1], s_data.hit_time}
                - {s_data.track_start[TIME_W-1], s_data.track_start};
        ad_next = diff[TIME_W] ? (TIME_W+1)'(-diff) : diff;
        a_side_next.charge = s_data.charge_density;
        a_side_next.apply  = tau_sel != '0;
        a_side_next.neg    = diff[TIME_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            c_valid_reg <= dv_valid;
            d_valid_reg <= c_valid_reg;
            p_valid_reg <= ex_valid;
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            a_ad_reg   <= ad_next;
            a_tau_reg  <= tau_sel;
            c_prod_reg <= PROD_W'(dv_quo) * PROD_W'(LOG2E_Q30);
            c_side_reg <= dv_side;
            d_frac_reg <= d_frac_next;
            d_side_reg <= d_side_next;
            p_prod_reg <= P_W'(ex_side.side.charge) * P_W'(ex_mant);
            p_side_reg <= ex_side;
            m_data_reg <= m_data_next;
        end
    end

    assign num = NUM_W'({a_ad_reg, {FRAC_W{1'b0}}}) + NUM_W'(a_tau_reg >> 1);

    dlcc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_num    (num),
        .in_tau    (a_tau_reg),
        .in_side   (a_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    always_comb begin
        ym = Q_W'((c_prod_reg + Y_HALF) >> 30);
        d_side_next.side = c_side_reg;
        if (c_side_reg.neg && (ym[FRAC_W-1:0] != '0)) begin
            d_side_next.exp_int = -N_W'(ym[Q_W-1:FRAC_W]) - N_W'(1);
            d_frac_next         = -ym[FRAC_W-1:0];
        end else if (c_side_reg.neg) begin
            d_side_next.exp_int = -N_W'(ym[Q_W-1:FRAC_W]);
            d_frac_next         = ym[FRAC_W-1:0];
        end else begin
            d_side_next.exp_int = N_W'(ym[Q_W-1:FRAC_W]);
            d_frac_next         = ym[FRAC_W-1:0];
        end
    end

    dlcc_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_frac   (d_frac_reg),
        .in_side   (d_side_reg),
        .out_valid (ex_valid),
        .out_mant  (ex_mant),
        .out_side  (ex_side)
    );

    always_comb begin
        shf     = (N_W+1)'(30) - {p_side_reg.exp_int[N_W-1], p_side_reg.exp_int};
        shf_neg = -shf;
        wide    = '0;
        m_data_next.corrected_charge = '0;
        m_data_next.lifetime_applied = p_side_reg.side.apply;
        m_data_next.saturated        = 1'b0;
        if (!p_side_reg.side.apply) begin
            m_data_next.corrected_charge = p_side_reg.side.charge;
        end else if (p_side_reg.side.charge == '0) begin
            m_data_next.corrected_charge = '0;
        end else if (p_side_reg.exp_int >= N_SAT) begin
            m_data_next.saturated = 1'b1;
        end else if (shf >= (N_W+1)'(63)) begin
            m_data_next.corrected_charge = '0;
        end else begin
            if (shf > (N_W+1)'(0)) begin
                wide = (W_W'(p_prod_reg) + (W_W'(1) << (shf[5:0] - 6'd1))) >> shf[5:0];
            end else begin
                wide = W_W'(p_prod_reg) << shf_neg[5:0];
            end
            if (wide > W_W'(MAXV)) begin
                m_data_next.saturated = 1'b1;
            end else begin
                m_data_next.corrected_charge = wide[CHARGE_W-1:0];
            end
        end
        if (m_data_next.saturated) begin
            m_data_next.corrected_charge = MAXV;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.saturated |-> m_data_reg.lifetime_applied)
        else $error("saturation flagged without a lifetime");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.saturated |-> m_data_reg.corrected_charge == MAXV)
        else $error("saturated charge not clipped to maximum");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !a_valid_reg && !p_valid_reg)
        else $error("pipeline valid survived reset");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift lifetime charge correction testbench
// Streams hits through the block, with random gaps on both sides except in the third setting, and
// checks every result against a fixed-point exp(drift / lifetime) predictor or a listed value.
// The lifetime registers go through several settings, written while idle:
// zero, one, mid-range and full-scale values.
// ----------------------------------------------------------------------------
module testbench;
    import dlcc_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 60;
    localparam logic [63:0] L2E    = 64'd1549082005;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [LT_W-1:0] cfg_wr_data = '0;

    logic [LT_W-1:0] lifetimes [4];
    logic [63:0] pow2_roots [17];
    out_t pending_charges [$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_gaps = 1'b0;

    typedef struct {
        in_t  hit;
        bit   known;
        out_t result;
    } hit_row_t;

    drift_lifetime_charge_correction u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic out_t correct_charge(input in_t h);
        logic [LT_W-1:0] tau;
        logic [63:0] ad, q, ym, m, p, v, maxv;
        longint d, n, s;
        logic [31:0] f;
        bit neg, sat;
        out_t r;
        maxv = (64'd1 << CHARGE_W) - 1;
        tau = 0;
        v = 0;
        sat = 0;
        if (h.cryostat < 2) tau = lifetimes[{h.cryostat[0], h.tpc_number[1]}];
        if (tau == 0) begin
            r.corrected_charge = h.charge_density;
            r.lifetime_applied = 1'b0;
            r.saturated = 1'b0;
            return r;
        end
        d = longint'(h.hit_time) - longint'(h.track_start);
        neg = d < 0;
        ad = neg ? -d : d;
        q = ((ad << FRAC_W) + (tau >> 1)) / tau;
        if (q > (64'd32 << FRAC_W)) q = 64'd32 << FRAC_W;
        ym = (q * L2E + (64'd1 << 29)) >> 30;
        f = 32'(ym[FRAC_W-1:0]);
        n = longint'(ym >> FRAC_W);
        if (neg) begin
            if (f == 0) n = -n;
            else begin
                n = -n - 1;
                f = (32'd1 << FRAC_W) - f;
            end
        end
        if (h.charge_density != 0) begin
            if (n >= CHARGE_W) sat = 1;
            else begin
                m = 64'd1 << 30;
                for (int k = 1; k <= FRAC_W; k++)
                    if (f[FRAC_W-k]) m = (m * pow2_roots[k] + (64'd1 << 29)) >> 30;
                p = h.charge_density * m;
                s = 30 - n;
                if (s >= 63) v = 0;
                else if (s > 0) v = (p + (64'd1 << (s - 1))) >> s;
                else if (s == 0) v = p;
                else if (p > (maxv >> (-s))) sat = 1;
                else v = p << (-s);
                if (v > maxv) sat = 1;
            end
        end
        if (sat) v = maxv;
        r.corrected_charge = v[CHARGE_W-1:0];
        r.lifetime_applied = 1'b1;
        r.saturated = sat;
        return r;
    endfunction

    task automatic write_lifetime(input cfg_idx_t idx, input logic [LT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        lifetimes[idx] = value;
    endtask

    task automatic send_hit(input in_t h, input bit known, input out_t res);
        while (!no_gaps && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pending_charges.push_back(known ? res : correct_charge(h));
        s_data <= h;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_charges.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic in_t random_hit();
        in_t h;
        h.charge_density = $urandom_range(3) == 0 ? CHARGE_W'($urandom)
                                                  : CHARGE_W'($urandom_range(4096));
        h.cryostat = $urandom_range(7) == 0 ? 2'($urandom_range(3, 2))
                                            : 2'($urandom_range(1));
        h.tpc_number = 2'($urandom);
        h.hit_time = TIME_W'($urandom);
        h.track_start = $urandom_range(1)
                      ? TIME_W'(h.hit_time - $signed($urandom_range(8000) - 4000))
                      : TIME_W'($urandom);
        return h;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_charges.size() == 0) begin
                $error("unexpected result %h", m_data);
                errors++;
            end else begin
                out_t e;
                e = pending_charges.pop_front();
                if (m_data.corrected_charge !== e.corrected_charge) begin
                    $error("corrected_charge exp %h got %h", e.corrected_charge,
                           m_data.corrected_charge);
                    errors++;
                end
                if (m_data.lifetime_applied !== e.lifetime_applied) begin
                    $error("lifetime_applied exp %b got %b", e.lifetime_applied,
                           m_data.lifetime_applied);
                    errors++;
                end
                if (m_data.saturated !== e.saturated) begin
                    $error("saturated exp %b got %b", e.saturated, m_data.saturated);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_gaps || $urandom_range(99) >= 34;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("drift_lifetime_charge_correction verification failed");
            $finish;
        end
    end

    initial begin
        hit_row_t rows [$];
        logic [LT_W-1:0] settings [4][4];
        pow2_roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) pow2_roots[k] = root_of(pow2_roots[k-1] << 30);
        for (int i = 0; i < 4; i++) lifetimes[i] = '0;
        settings = '{'{24'd16000, 24'd1, 24'hFFFFFF, 24'd0},
                     '{24'd1, 24'd2, 24'd3, 24'd4},
                     '{24'hFFFFFF, 24'hFFFFFE, 24'd800000, 24'd100},
                     '{24'd0, 24'd48000, 24'd7, 24'd3000}};
        // after reset all lifetimes are zero: pass through
        rows.push_back('{'{24'hFFFFFF, 2'd0, 2'd0, 24'sh7FFFFF, 24'sh800000}, 1,
                         '{24'hFFFFFF, 1'b0, 1'b0}});
        rows.push_back('{'{24'd0, 2'd1, 2'd3, 24'sd5, 24'sd0}, 1, '{24'd0, 1'b0, 1'b0}});
        rows.push_back('{'{24'd256, 2'd3, 2'd2, 24'sd0, 24'sd0}, 1, '{24'd256, 1'b0, 1'b0}});
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i]) send_hit(rows[i].hit, rows[i].known, rows[i].result);
        wait_idle();
        rows.delete();
        for (int s = 0; s < 4; s++) begin
            write_lifetime(REG_EAST_EAST, settings[s][0]);
            write_lifetime(REG_EAST_WEST, settings[s][1]);
            write_lifetime(REG_WEST_EAST, settings[s][2]);
            write_lifetime(REG_WEST_WEST, settings[s][3]);
            cfg_wr_en <= 1'b0;
            if (s == 0) begin
                // extremes: zero drift, max drift both signs, no-lifetime cryostat
                rows.push_back('{'{24'd256, 2'd0, 2'd0, 24'sd0, 24'sd0}, 1,
                                 '{24'd256, 1'b1, 1'b0}});
                rows.push_back('{'{24'd0, 2'd0, 2'd2, 24'sh7FFFFF, 24'sh800000}, 1,
                                 '{24'd0, 1'b1, 1'b0}});
                rows.push_back('{'{24'hFFFFFF, 2'd0, 2'd2, 24'sh7FFFFF, 24'sh800000}, 1,
                                 '{24'hFFFFFF, 1'b1, 1'b1}});
                rows.push_back('{'{24'hFFFFFF, 2'd0, 2'd3, 24'sh800000, 24'sh7FFFFF}, 1,
                                 '{24'd0, 1'b1, 1'b0}});
                rows.push_back('{'{24'd1234, 2'd2, 2'd1, 24'sd100, 24'sd0}, 1,
                                 '{24'd1234, 1'b0, 1'b0}});
                rows.push_back('{'{24'd1234, 2'd1, 2'd3, 24'sd100, 24'sd0}, 1,
                                 '{24'd1234, 1'b0, 1'b0}});
                rows.push_back('{'{24'h012345, 2'd0, 2'd1, 24'sd16000, 24'sd0}, 0, '0});
                rows.push_back('{'{24'h012345, 2'd1, 2'd0, -24'sd16000, 24'sd0}, 0, '0});
                rows.push_back('{'{24'hFFFFFF, 2'd1, 2'd1, 24'sd10, 24'sd0}, 0, '0});
                rows.push_back('{'{24'h000001, 2'd1, 2'd1, -24'sd9000, 24'sd0}, 0, '0});
                foreach (rows[i]) send_hit(rows[i].hit, rows[i].known, rows[i].result);
            end
            no_gaps = (s == 2);
            for (int i = 0; i < 150; i++) send_hit(random_hit(), 0, '0);
            no_gaps = 1'b0;
            wait_idle();
        end
        if (errors == 0) begin
            $display("drift_lifetime_charge_correction verification clean");
        end else begin
            $display("drift_lifetime_charge_correction verification failed");
        end
        $finish;
    end
endmodule

>>> drift_lifetime_charge_correction.f
src/dlcc_pkg.sv
src/dlcc_div.sv
src/dlcc_exp2.sv
src/drift_lifetime_charge_correction.sv
bench/testbench.sv
